// ===== rtl/core/dmxa_pkg.sv =====
// Shared types, widths, codes and control store for the mutex agent.
package dmxa_pkg;

  // Widths and sizes
  localparam int MAX_NODES  = 16;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int OP_W       = 2;
  localparam int PEER_W     = 4;
  localparam int TS_W       = 32;
  localparam int KIND_W     = 2;
  localparam int RANK_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PC_W       = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

  // Event codes
  typedef enum logic [OP_W-1:0] {
    OP_LOCAL_REQ   = 2'd0,
    OP_PEER_REQ    = 2'd1,
    OP_PEER_REPLY  = 2'd2,
    OP_LOCAL_EXIT  = 2'd3
  } op_t;

  // Outgoing message codes
  typedef enum logic [KIND_W-1:0] {
    MSG_NONE    = 2'd0,
    MSG_REQUEST = 2'd1,
    MSG_REPLY   = 2'd2
  } kind_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_WANTING,
    COND_NOT_WANTING,
    COND_INVALID,
    COND_DEFER,
    COND_PEND_EMPTY
  } cond_t;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_FETCH,
    ACT_START_REQ,
    ACT_RECEIVE,
    ACT_START_EXIT,
    ACT_LOAD_REPLY,
    ACT_SET_REPLY,
    ACT_SET_DEFER,
    ACT_SEND,
    ACT_STATUS
  } act_t;

  // One control word: on cond, jump to jmp without acting; else act and go to nxt
  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] jmp;
    act_t            act;
    logic [PC_W-1:0] nxt;
  } ctrl_t;

  // Program addresses; the four event entries follow fetch in op order
  localparam logic [PC_W-1:0] PC_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] PC_LREQ   = 4'd1;
  localparam logic [PC_W-1:0] PC_PREQ   = 4'd2;
  localparam logic [PC_W-1:0] PC_PREP   = 4'd3;
  localparam logic [PC_W-1:0] PC_EXIT   = 4'd4;
  localparam logic [PC_W-1:0] PC_PREQ2  = 4'd5;
  localparam logic [PC_W-1:0] PC_PREP2  = 4'd6;
  localparam logic [PC_W-1:0] PC_DEFER  = 4'd7;
  localparam logic [PC_W-1:0] PC_SEND   = 4'd8;
  localparam logic [PC_W-1:0] PC_STATUS = 4'd9;

  // Control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      PC_FETCH:  cw = '{COND_NEVER,       PC_FETCH,  ACT_FETCH,      PC_LREQ};
      PC_LREQ:   cw = '{COND_WANTING,     PC_STATUS, ACT_START_REQ,  PC_SEND};
      PC_PREQ:   cw = '{COND_INVALID,     PC_STATUS, ACT_RECEIVE,    PC_PREQ2};
      PC_PREP:   cw = '{COND_INVALID,     PC_STATUS, ACT_RECEIVE,    PC_PREP2};
      PC_EXIT:   cw = '{COND_NOT_WANTING, PC_STATUS, ACT_START_EXIT, PC_SEND};
      PC_PREQ2:  cw = '{COND_DEFER,       PC_DEFER,  ACT_LOAD_REPLY, PC_SEND};
      PC_PREP2:  cw = '{COND_NOT_WANTING, PC_STATUS, ACT_SET_REPLY,  PC_STATUS};
      PC_DEFER:  cw = '{COND_NEVER,       PC_FETCH,  ACT_SET_DEFER,  PC_STATUS};
      PC_SEND:   cw = '{COND_PEND_EMPTY,  PC_STATUS, ACT_SEND,       PC_FETCH};
      PC_STATUS: cw = '{COND_NEVER,       PC_FETCH,  ACT_STATUS,     PC_FETCH};
      default:   cw = '{COND_NEVER,       PC_FETCH,  ACT_STATUS,     PC_FETCH};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/dmxa_in_if.sv =====
// Event input channel: valid/ready with one event per transfer.
interface dmxa_in_if import dmxa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PEER_W-1:0] peer_node;
  logic [TS_W-1:0]   peer_timestamp;

  modport source (output valid, output operation, output peer_node,
                  output peer_timestamp, input ready);
  modport sink   (input valid, input operation, input peer_node,
                  input peer_timestamp, output ready);
endinterface

// ===== rtl/core/dmxa_out_if.sv =====
// Result channel: valid/ready with one message or status per transfer.
interface dmxa_out_if import dmxa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] message_kind;
  logic [PEER_W-1:0] dest_node;
  logic [TS_W-1:0]   message_timestamp;
  logic              lock_held;
  logic              last;

  modport source (output valid, output message_kind, output dest_node,
                  output message_timestamp, output lock_held, output last,
                  input ready);
  modport sink   (input valid, input message_kind, input dest_node,
                  input message_timestamp, input lock_held, input last,
                  output ready);
endinterface

// ===== rtl/core/distributed_mutex_agent_unit.sv =====
// Ricart-Agrawala mutex node with Lamport clock, run by a small microcoded sequencer.
//
//   channel   direction  handshake          payload
//   in_chan   in         valid/ready        operation, peer_node, peer_timestamp
//   out_chan  out        valid/ready        message_kind, dest_node, message_timestamp,
//                                            lock_held, last
//   cfg_*     in         write enable only  cfg_index selects node_rank / node_count
//
// An event is taken in the fetch step, then runs 2 to 4 control steps. Message
// fan-out scans node slots one per cycle, holding at a pending slot while the
// output register is busy; a reply to a peer request scans only up to the peer's
// slot. Each result waits for a free output register, which stalls the sequencer
// while out_chan.ready is low. Reset (rst_n low, synchronous) clears clock and
// request state, sets node_rank to 0 and node_count to 16.
module distributed_mutex_agent_unit import dmxa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dmxa_in_if.sink               in_chan,
  dmxa_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer and node state
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PEER_W-1:0]    peer_r, peer_nxt;
  logic [TS_W-1:0]      ts_r, ts_nxt;
  logic [TS_W-1:0]      clock_r, clock_nxt;
  logic [TS_W-1:0]      own_time_r, own_time_nxt;
  logic                 wanting_r, wanting_nxt;
  logic [MAX_NODES-1:0] replies_r, replies_nxt;
  logic [MAX_NODES-1:0] deferred_r, deferred_nxt;
  logic [MAX_NODES-1:0] pending_r, pending_nxt;
  logic [NODE_W-1:0]    idx_r, idx_nxt;
  kind_t                kind_r, kind_nxt;
  logic [RANK_W-1:0]    rank_r;
  logic [COUNT_W-1:0]   count_r;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [PEER_W-1:0]    out_dest_r, out_dest_nxt;
  logic [TS_W-1:0]      out_ts_r, out_ts_nxt;
  logic                 out_lock_r, out_lock_nxt;
  logic                 out_last_r, out_last_nxt;

  ctrl_t                cw;
  logic                 cond_hit;
  logic [MAX_NODES-1:0] peers_mask;
  logic [MAX_NODES-1:0] peer_onehot;
  logic [MAX_NODES-1:0] idx_onehot;
  logic [MAX_NODES-1:0] pending_left;
  logic                 peer_valid;
  logic                 lock_held;
  logic                 defer;
  logic                 slot_free;
  logic [TS_W-1:0]      stamp_max;

  // Peer set, one-hot selects
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      peers_mask[i]  = (int'(count_r) > i) && (int'(rank_r) != i);
      peer_onehot[i] = (int'(peer_r) == i);
      idx_onehot[i]  = (int'(idx_r) == i);
    end
  end

  assign peer_valid   = |(peers_mask & peer_onehot);
  assign lock_held    = wanting_r && ((replies_r & peers_mask) == peers_mask);
  assign defer        = wanting_r && ((own_time_r < ts_r) ||
                        ((own_time_r == ts_r) && (rank_r < peer_r)));
  assign stamp_max    = (ts_r > clock_r) ? ts_r : clock_r;
  assign pending_left = pending_r & ~idx_onehot;
  assign slot_free    = !out_valid_r || out_chan.ready;

  // Control word and jump test
  assign cw = ucode(pc_r);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:       cond_hit = 1'b0;
      COND_WANTING:     cond_hit = wanting_r;
      COND_NOT_WANTING: cond_hit = !wanting_r;
      COND_INVALID:     cond_hit = !peer_valid;
      COND_DEFER:       cond_hit = defer;
      COND_PEND_EMPTY:  cond_hit = (pending_r == '0);
      default:          cond_hit = 1'b0;
    endcase
  end

  assign in_chan.ready = (cw.act == ACT_FETCH);

  // Datapath driven by the current control word
  always_comb begin
    pc_nxt        = pc_r;
    peer_nxt      = peer_r;
    ts_nxt        = ts_r;
    clock_nxt     = clock_r;
    own_time_nxt  = own_time_r;
    wanting_nxt   = wanting_r;
    replies_nxt   = replies_r;
    deferred_nxt  = deferred_r;
    pending_nxt   = pending_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_dest_nxt  = out_dest_r;
    out_ts_nxt    = out_ts_r;
    out_lock_nxt  = out_lock_r;
    out_last_nxt  = out_last_r;

    if (cond_hit) begin
      pc_nxt = cw.jmp;
    end else begin
      unique case (cw.act)
        ACT_FETCH: begin
          if (in_chan.valid) begin
            peer_nxt = in_chan.peer_node;
            ts_nxt   = in_chan.peer_timestamp;
            pc_nxt   = PC_LREQ + PC_W'(in_chan.operation);
          end
        end
        ACT_START_REQ: begin
          wanting_nxt  = 1'b1;
          replies_nxt  = '0;
          own_time_nxt = clock_r + 1'b1;
          pending_nxt  = peers_mask;
          kind_nxt     = MSG_REQUEST;
          idx_nxt      = '0;
          pc_nxt       = cw.nxt;
        end
        ACT_RECEIVE: begin
          clock_nxt = stamp_max + 1'b1;
          pc_nxt    = cw.nxt;
        end
        ACT_START_EXIT: begin
          wanting_nxt  = 1'b0;
          replies_nxt  = '0;
          pending_nxt  = deferred_r & peers_mask;
          deferred_nxt = '0;
          kind_nxt     = MSG_REPLY;
          idx_nxt      = '0;
          pc_nxt       = cw.nxt;
        end
        ACT_LOAD_REPLY: begin
          pending_nxt = peer_onehot;
          kind_nxt    = MSG_REPLY;
          idx_nxt     = '0;
          pc_nxt      = cw.nxt;
        end
        ACT_SET_REPLY: begin
          replies_nxt = replies_r | peer_onehot;
          pc_nxt      = cw.nxt;
        end
        ACT_SET_DEFER: begin
          deferred_nxt = deferred_r | peer_onehot;
          pc_nxt       = cw.nxt;
        end
        ACT_SEND: begin
          // scan one node slot per cycle, emit where a message is pending; hold there while the output is busy
          if (|(pending_r & idx_onehot)) begin
            if (slot_free) begin
              clock_nxt     = clock_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = kind_r;
              out_dest_nxt  = PEER_W'(idx_r);
              out_ts_nxt    = clock_r + 1'b1;
              out_lock_nxt  = lock_held;
              out_last_nxt  = (pending_left == '0);
              pending_nxt   = pending_left;
              idx_nxt       = idx_r + 1'b1;
              if (pending_left == '0) begin
                pc_nxt = cw.nxt;
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ACT_STATUS: begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = MSG_NONE;
            out_dest_nxt  = '0;
            out_ts_nxt    = '0;
            out_lock_nxt  = lock_held;
            out_last_nxt  = 1'b1;
            pc_nxt        = cw.nxt;
          end
        end
        default: begin
          pc_nxt = PC_FETCH;
        end
      endcase
    end
  end

  // Control and node state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_FETCH;
      clock_r     <= '0;
      own_time_r  <= '0;
      wanting_r   <= 1'b0;
      replies_r   <= '0;
      deferred_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      clock_r     <= clock_nxt;
      own_time_r  <= own_time_nxt;
      wanting_r   <= wanting_nxt;
      replies_r   <= replies_nxt;
      deferred_r  <= deferred_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event and result payload
  always_ff @(posedge clk) begin
    peer_r     <= peer_nxt;
    ts_r       <= ts_nxt;
    pending_r  <= pending_nxt;
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_dest_r <= out_dest_nxt;
    out_ts_r   <= out_ts_nxt;
    out_lock_r <= out_lock_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= '0;
      count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NODE_RANK:  rank_r  <= cfg_wdata[RANK_W-1:0];
        CFG_NODE_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.message_kind      = out_kind_r;
  assign out_chan.dest_node         = out_dest_r;
  assign out_chan.message_timestamp = out_ts_r;
  assign out_chan.lock_held         = out_lock_r;
  assign out_chan.last              = out_last_r;

endmodule
